>>> hdl/polyline_arc_length_resampler_top_defines.svh
// Assertion macros for the checker file.
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH
// Implication checked every clock edge outside reset.
`define PALR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock edge outside reset.
`define PALR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/palr_pkg.sv
// ----------------------------------------------------------------------------
// palr_pkg
// Shared types and constants of the arc-length resampler.
// ----------------------------------------------------------------------------
package palr_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic               func;
    logic               start_new;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic signed [31:0] lat_x, lat_y, lat_z;
    logic        [31:0] query_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [31:0] out_dir_x, out_dir_y, out_dir_z;
    logic signed [31:0] out_lat_x, out_lat_y, out_lat_z;
    logic               table_empty;
    logic               past_end;
  } out_item_t;

  // Point record stored in one memory word: nine components.
  typedef logic [9*32-1:0] point_word_t;
endpackage

>>> hdl/palr_if.sv
// ----------------------------------------------------------------------------
// palr_in_if / palr_out_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface palr_in_if;
  logic                valid;
  logic                ready;
  palr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface palr_out_if;
  logic                valid;
  logic                ready;
  palr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/palr_ram.sv
// ----------------------------------------------------------------------------
// palr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module palr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/palr_sqrt.sv
// ----------------------------------------------------------------------------
// palr_sqrt
// Bit-serial floor square root of a 66-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module palr_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [65:0] radicand,
  output logic        done,
  output logic [32:0] root
);
  logic [65:0] val_r;
  logic [35:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [35:0] rem_sh, trial;

  assign rem_sh = {rem_r[33:0], val_r[65:64]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        val_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r <= {val_r[63:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[31:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end
endmodule

>>> hdl/palr_div.sv
// ----------------------------------------------------------------------------
// palr_div
// Restoring divider: (off << FRAC_BITS) / seg, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module palr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] off,
  input  logic [31:0] seg,
  output logic        done,
  output logic [47:0] quot
);
  localparam int unsigned NB = 32 + palr_pkg::FRAC_BITS;
  logic [NB-1:0] num_r;
  logic [32:0]   rem_r;
  logic [31:0]   seg_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic [32:0]   rem_sh;

  assign rem_sh = {rem_r[31:0], num_r[NB-1]};
  assign quot   = 48'(num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NB - 1);
        num_r  <= {off, {palr_pkg::FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        seg_r  <= seg;
      end else if (busy_r) begin
        // Quotient bits shift in where numerator bits leave.
        if (rem_sh >= {1'b0, seg_r}) begin
          rem_r <= rem_sh - {1'b0, seg_r};
          num_r <= {num_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[NB-2:0], 1'b0};
        end
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end
endmodule

>>> hdl/polyline_arc_length_resampler_top.sv
// Append: squared differences, then the bit-serial square root (33 steps).
// Query: bisection over the length RAM, the 48-step divider, then nine
// interpolations through one multiplier.
// One item at a time; the result register frees the input side once loaded.
// Synchronous active-low reset clears point count and running length; RAMs
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_top
// Track point table with arc-length lookup and linear interpolation.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler_top #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  palr_in_if.sink         in_ch,
  palr_out_if.source      out_ch
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned FB = palr_pkg::FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_APP_SQ, S_APP_SQRT, S_APP_WR,
    S_Q_LAST, S_Q_LASTW, S_Q_BIS, S_Q_BISW, S_Q_FIX, S_Q_FIXW,
    S_Q_LI, S_Q_LIW, S_Q_LI1, S_Q_LI1W, S_Q_DIV, S_Q_DIVW,
    S_Q_PA, S_Q_PAW, S_Q_PB, S_Q_PBW, S_Q_MUL, S_Q_ACC, S_Q_OUT
  } state_t;

  state_t state_r;
  palr_pkg::in_item_t req_r;
  logic [CW-1:0] count_r;
  logic signed [31:0] prev_r [3];
  logic [31:0] run_r;

  // memories
  logic          len_we, pt_we;
  logic [AW-1:0] len_addr, pt_addr;
  logic [31:0]   len_wdata, len_rdata;
  palr_pkg::point_word_t pt_wdata, pt_rdata;

  palr_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_len (
    .clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wdata), .rdata(len_rdata));
  palr_ram #(.WIDTH(9*32), .DEPTH(MAX_POINTS)) u_pt (
    .clk(clk), .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata));

  // working registers
  logic [AW-1:0] lo_r, hi_r, idx_r;
  logic [31:0]   lenA_r, lenB_r;
  logic [65:0]   sumsq_r;
  logic [1:0]    k_r;
  logic [3:0]    c_r;
  logic [FB:0]   t_r;
  palr_pkg::point_word_t pa_r, pb_r;
  logic signed [32+FB+1:0] prod_r;
  logic signed [31:0] res_r [9];
  logic empty_r, past_r;
  palr_pkg::out_item_t out_r;
  logic out_valid_r;

  // square-root and divider units
  logic        sq_start, sq_done, dv_start, dv_done;
  logic [32:0] sq_root;
  logic [47:0] dv_q;
  logic [31:0] dv_off;

  palr_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sumsq_r),
                    .done(sq_done), .root(sq_root));
  palr_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start),
                  .off(dv_off), .seg(lenB_r - lenA_r), .done(dv_done), .quot(dv_q));

  assign dv_off = (req_r.query_distance >= lenA_r) ? req_r.query_distance - lenA_r : '0;

  // one squared difference per cycle
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [65:0] sq;
  always_comb begin
    case (k_r)
      2'd0:    diff = 33'(req_r.pos_x) - 33'(prev_r[0]);
      2'd1:    diff = 33'(req_r.pos_y) - 33'(prev_r[1]);
      default: diff = 33'(req_r.pos_z) - 33'(prev_r[2]);
    endcase
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    sq  = 66'(mag) * 66'(mag);
  end

  logic [32:0] run_sum;
  assign run_sum = 33'(run_r) + 33'(sq_root[31:0]);

  logic [AW-1:0] mid, last_idx;
  assign mid      = lo_r + AW'((hi_r - lo_r) >> 1);
  assign last_idx = AW'(count_r - CW'(1));

  logic signed [31:0] ca, cb;
  always_comb begin
    ca = pa_r[c_r*32 +: 32];
    cb = pb_r[c_r*32 +: 32];
  end

  logic empty_append;
  assign empty_append = req_r.start_new || (count_r == '0);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    len_we = 1'b0; pt_we = 1'b0;
    len_addr = idx_r; pt_addr = idx_r;
    len_wdata = run_r;
    pt_wdata = {req_r.lat_z, req_r.lat_y, req_r.lat_x, req_r.dir_z, req_r.dir_y,
                req_r.dir_x, req_r.pos_z, req_r.pos_y, req_r.pos_x};
    sq_start = 1'b0; dv_start = 1'b0;
    case (state_r)
      S_APP_WR: begin len_we = 1'b1; pt_we = 1'b1; end
      S_Q_LAST: begin len_addr = last_idx; pt_addr = last_idx; end
      S_Q_BIS:  len_addr = mid;
      S_Q_FIX:  len_addr = lo_r;
      S_Q_LI1:  len_addr = idx_r + AW'(1);
      S_Q_PB:   pt_addr = idx_r + AW'(1);
      default: ;
    endcase
    if (state_r == S_APP_SQ && k_r == 2'd3) sq_start = 1'b1;
    if (state_r == S_Q_DIV) dv_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      run_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) prev_r[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data;
            k_r <= '0;
            sumsq_r <= '0;
            if (in_ch.data.func == palr_pkg::FUNC_QUERY) begin
              state_r <= (count_r == '0) ? S_Q_OUT : S_Q_LAST;
              for (int i = 0; i < 9; i++) res_r[i] <= '0;
              empty_r <= (count_r == '0);
              past_r <= 1'b0;
            end else begin
              state_r <= S_APP_SQ;
            end
          end
        end
        S_APP_SQ: begin
          if (empty_append) begin
            // First point of a track: stored at zero length.
            if (req_r.start_new) count_r <= '0;
            idx_r <= '0;
            run_r <= '0;
            state_r <= S_APP_WR;
          end else if (count_r == CW'(MAX_POINTS)) begin
            state_r <= S_IDLE;
          end else if (k_r == 2'd3) begin
            state_r <= S_APP_SQRT;
          end else begin
            sumsq_r <= sumsq_r + sq;
            k_r <= k_r + 2'd1;
          end
        end
        S_APP_SQRT: begin
          if (sq_done) begin
            run_r <= (sq_root[32] || run_sum[32]) ? 32'hFFFF_FFFF : run_sum[31:0];
            idx_r <= AW'(count_r);
            state_r <= S_APP_WR;
          end
        end
        S_APP_WR: begin
          count_r <= CW'(idx_r) + CW'(1);
          prev_r[0] <= req_r.pos_x; prev_r[1] <= req_r.pos_y; prev_r[2] <= req_r.pos_z;
          state_r <= S_IDLE;
        end
        S_Q_LAST: state_r <= S_Q_LASTW;
        S_Q_LASTW: begin
          if (req_r.query_distance >= len_rdata) begin
            for (int i = 0; i < 9; i++) res_r[i] <= pt_rdata[i*32 +: 32];
            past_r <= 1'b1;
            state_r <= S_Q_OUT;
          end else begin
            lo_r <= '0; hi_r <= last_idx;
            state_r <= S_Q_BIS;
          end
        end
        S_Q_BIS: state_r <= (lo_r < hi_r) ? S_Q_BISW : S_Q_FIX;
        S_Q_BISW: begin
          if (len_rdata >= req_r.query_distance) hi_r <= mid;
          else lo_r <= mid + AW'(1);
          state_r <= S_Q_BIS;
        end
        S_Q_FIX: state_r <= S_Q_FIXW;
        S_Q_FIXW: begin
          idx_r <= (len_rdata == req_r.query_distance || lo_r == '0) ? lo_r : lo_r - AW'(1);
          state_r <= S_Q_LI;
        end
        S_Q_LI:   state_r <= S_Q_LIW;
        S_Q_LIW:  begin lenA_r <= len_rdata; state_r <= S_Q_LI1; end
        S_Q_LI1:  state_r <= S_Q_LI1W;
        S_Q_LI1W: begin lenB_r <= len_rdata; state_r <= S_Q_DIV; end
        S_Q_DIV:  state_r <= S_Q_DIVW;
        S_Q_DIVW: begin
          if (lenB_r == lenA_r) begin
            t_r <= (FB+1)'(1) << (FB - 1);
            state_r <= S_Q_PA;
          end else if (dv_done) begin
            t_r <= (dv_q > 48'(1 << FB)) ? (FB+1)'(1 << FB) : dv_q[FB:0];
            state_r <= S_Q_PA;
          end
        end
        S_Q_PA:  state_r <= S_Q_PAW;
        S_Q_PAW: begin pa_r <= pt_rdata; state_r <= S_Q_PB; end
        S_Q_PB:  state_r <= S_Q_PBW;
        S_Q_PBW: begin pb_r <= pt_rdata; c_r <= '0; state_r <= S_Q_MUL; end
        // The product of the current component is registered at the end of this cycle.
        S_Q_MUL: state_r <= S_Q_ACC;
        S_Q_ACC: begin
          // Arithmetic shift floors toward minus infinity.
          res_r[c_r] <= 32'(ca + 32'(prod_r >>> FB));
          if (c_r == 4'd8) state_r <= S_Q_OUT;
          else begin c_r <= c_r + 4'd1; state_r <= S_Q_MUL; end
        end
        S_Q_OUT: begin
          if (!out_valid_r) begin
            out_r.out_pos_x <= res_r[0]; out_r.out_pos_y <= res_r[1];
            out_r.out_pos_z <= res_r[2]; out_r.out_dir_x <= res_r[3];
            out_r.out_dir_y <= res_r[4]; out_r.out_dir_z <= res_r[5];
            out_r.out_lat_x <= res_r[6]; out_r.out_lat_y <= res_r[7];
            out_r.out_lat_z <= res_r[8];
            out_r.table_empty <= empty_r;
            out_r.past_end <= past_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // multiplier stage, registered separately
  always_ff @(posedge clk) begin
    prod_r <= (32+FB+2)'(33'(cb) - 33'(ca)) * (32+FB+2)'($signed({1'b0, t_r}));
  end
endmodule

>>> hdl/palr_checker.sv
// ----------------------------------------------------------------------------
// palr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "polyline_arc_length_resampler_top_defines.svh"
module palr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic table_empty,
  input logic past_end
);
  `PALR_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid, !(table_empty && past_end))
  `PALR_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `PALR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind polyline_arc_length_resampler_top palr_checker u_palr_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .table_empty(out_ch.data.table_empty), .past_end(out_ch.data.past_end));
